>>> rtl/core/gsrd_pkg.sv
// shared types and constants for the gray-scott stencil block
// no dependencies; imported by every module of the block
package gsrd_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int DIM_W  = 11;                     // grid size register width
  localparam int POS_W  = $clog2(MAX_WIDTH);      // row / column position
  localparam int CONC_W = 16;                     // q1.15 concentration
  localparam int PAR_W  = 16;                     // rate registers
  localparam int ADDR_W = $clog2(2 * MAX_WIDTH);  // two-row line store
  localparam int LAP_W  = 23;                     // 20 * laplacian, signed
  localparam int VAL_W  = 58;                     // rate numerators and products
  localparam int MPL_W  = 17;                     // serial multiplier operand
  localparam int QUO_W  = 42;                     // numerator after the 2^16 shift
  localparam int CNT_W  = 6;                      // unit step counter
  localparam int REM_W  = 5;                      // remainder of the divide by 20
  localparam int IDX_W  = 3;

  localparam int DIG_W     = 21;                  // quotient digit per divide step
  localparam int DV_W      = REM_W + DIG_W;       // partial dividend of one step
  localparam int DVP_W     = 53;                  // partial dividend times reciprocal
  localparam int DIV_STEPS = QUO_W / DIG_W;       // digits per divide
  localparam int DIV_RCP   = 107374183;           // ceil(2^31 / 20)
  localparam int RCP_SHIFT = 31;

  localparam int DIV_DEN   = 20;
  localparam int DIV_SHIFT = 16;
  localparam int DT_SHIFT  = 29;
  localparam int ONE_Q15   = 32768;

  typedef enum logic [IDX_W-1:0] {
    REG_GRID_WIDTH  = 3'd0,
    REG_GRID_HEIGHT = 3'd1,
    REG_DIFF_A      = 3'd2,
    REG_DIFF_B      = 3'd3,
    REG_FEED        = 3'd4,
    REG_KILL        = 3'd5,
    REG_TIME_STEP   = 3'd6,
    REG_UNUSED      = 3'd7
  } reg_idx_e;

  typedef enum logic [3:0] {
    OP_AB  = 4'd0,  // a * b
    OP_ABB = 4'd1,  // (a*b) * b
    OP_DA  = 4'd2,  // da * lap(a)
    OP_FA  = 4'd3,  // f * (1 - a)
    OP_DB  = 4'd4,  // db * lap(b)
    OP_KB  = 4'd5,  // (k + f) * b
    OP_DVA = 4'd6,  // rate of a, rounded to q.30
    OP_DTA = 4'd7,  // rate of a * dt
    OP_DVB = 4'd8,
    OP_DTB = 4'd9
  } op_e;

  typedef struct packed {
    logic accept;
    logic shift;
    logic start;
    logic capture;
    logic load_out;
    op_e  op;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic interior;
    logic unit_done;
    logic out_free;
  } stat_t;

endpackage

>>> rtl/core/gray_scott_reaction_diffusion_step.sv
// gray-scott reaction-diffusion stencil, one cell per input beat in raster order
// a cell with no result goes back to idle after the window shift, a border cell is loaded
// once the output is free, and an interior cell first runs 8 shift-add multiplies and two
// divides by 20 one after another in the shared serial unit
// the output register lets the next cell in while a result beat waits
// reset (async, active low) restores register defaults and counters; line stores are not cleared
module gray_scott_reaction_diffusion_step import gsrd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration writes
  input  logic              cfg_we_i,
  input  logic [IDX_W-1:0]  cfg_idx_i,
  input  logic [PAR_W-1:0]  cfg_wdata_i,
  // cell input channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CONC_W-1:0] conc_a_i,
  input  logic [CONC_W-1:0] conc_b_i,
  input  logic              first_of_frame_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CONC_W-1:0] new_a_o,
  output logic [CONC_W-1:0] new_b_o,
  output logic [7:0]        luminance_o,
  output logic [POS_W-1:0]  out_row_o,
  output logic [POS_W-1:0]  out_col_o
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer: accept, shift window, step through the arithmetic, load result
  gsrd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // line stores, windows, counters, serial arithmetic and output register
  gsrd_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .conc_a_i         (conc_a_i),
    .conc_b_i         (conc_b_i),
    .first_of_frame_i (first_of_frame_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .new_a_o          (new_a_o),
    .new_b_o          (new_b_o),
    .luminance_o      (luminance_o),
    .out_row_o        (out_row_o),
    .out_col_o        (out_col_o)
  );

endmodule

>>> rtl/core/gsrd_unit.sv
// shared serial arithmetic unit: shift-add multiply and a two-digit reciprocal divide by 20
// depends on gsrd_pkg
module gsrd_unit import gsrd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic                    is_div_i,
  input  logic signed [VAL_W-1:0] mcand_i,
  input  logic        [MPL_W-1:0] mplier_i,
  input  logic signed [VAL_W-1:0] num_i,
  output logic                    done_o,
  output logic signed [VAL_W-1:0] result_o
);

  logic                    busy_q, done_q, div_q, neg_q;
  logic [CNT_W-1:0]        cnt_q;
  logic signed [VAL_W-1:0] acc_q, md_q;
  logic [MPL_W-1:0]        mr_q;
  logic [QUO_W-1:0]        n_q;
  logic [REM_W-1:0]        rem_q;
  logic [DV_W-1:0]         dv;
  logic [DVP_W-1:0]        dprod;
  logic [DIG_W-1:0]        dq;
  logic [DV_W-1:0]         dq20;
  logic [VAL_W-1:0]        mag;
  logic [VAL_W-1:0]        biased;
  logic signed [VAL_W-1:0] quo;

  // one quotient digit per step: remainder and next digit over 20
  assign dv     = {rem_q, n_q[QUO_W-1 -: DIG_W]};
  assign dprod  = DVP_W'(dv) * DVP_W'(DIV_RCP);
  assign dq     = dprod[RCP_SHIFT +: DIG_W];
  assign dq20   = (DV_W'(dq) << 4) + (DV_W'(dq) << 2);
  assign mag    = num_i[VAL_W-1] ? VAL_W'(-num_i) : VAL_W'(num_i);
  assign biased = mag + VAL_W'((DIV_DEN / 2) << DIV_SHIFT);
  assign quo    = signed'(VAL_W'(n_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      div_q  <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      div_q  <= is_div_i;
      cnt_q  <= is_div_i ? CNT_W'(DIV_STEPS) : CNT_W'(MPL_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      md_q  <= mcand_i;
      mr_q  <= mplier_i;
      neg_q <= num_i[VAL_W-1];
      n_q   <= QUO_W'(biased >> DIV_SHIFT);
      rem_q <= '0;
    end else if (busy_q) begin
      if (div_q) begin
        rem_q <= REM_W'(dv - dq20);
        n_q   <= {n_q[QUO_W-DIG_W-1:0], dq};
      end else begin
        if (mr_q[0]) acc_q <= acc_q + md_q;
        md_q <= md_q <<< 1;
        mr_q <= mr_q >> 1;
      end
    end
  end

  assign done_o   = done_q;
  assign result_o = div_q ? (neg_q ? -quo : quo) : acc_q;

endmodule

>>> rtl/core/gsrd_dp.sv
// datapath: registers, line stores, 3x3 windows, counters, serial unit, output beat
// depends on gsrd_pkg and gsrd_unit
module gsrd_dp import gsrd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output stat_t             stat_o,
  input  logic              cfg_we_i,
  input  logic [IDX_W-1:0]  cfg_idx_i,
  input  logic [PAR_W-1:0]  cfg_wdata_i,
  input  logic [CONC_W-1:0] conc_a_i,
  input  logic [CONC_W-1:0] conc_b_i,
  input  logic              first_of_frame_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CONC_W-1:0] new_a_o,
  output logic [CONC_W-1:0] new_b_o,
  output logic [7:0]        luminance_o,
  output logic [POS_W-1:0]  out_row_o,
  output logic [POS_W-1:0]  out_col_o
);

  function automatic logic [CONC_W-1:0] settle(logic [CONC_W-1:0] old,
                                               logic signed [VAL_W-1:0] p);
    logic [VAL_W-1:0]       m;
    logic [VAL_W-1:0]       d;
    logic signed [30:0]     v;
    m = p[VAL_W-1] ? VAL_W'(-p) : VAL_W'(p);
    d = (m + (VAL_W'(1) << (DT_SHIFT - 1))) >> DT_SHIFT;
    v = signed'(31'(old)) + (p[VAL_W-1] ? -signed'(31'(d)) : signed'(31'(d)));
    if (v < 0) return '0;
    if (v > 31'(ONE_Q15)) return CONC_W'(ONE_Q15);
    return v[CONC_W-1:0];
  endfunction

  function automatic logic signed [LAP_W-1:0] lap20(logic [8:0][CONC_W-1:0] w);
    logic [LAP_W-1:0] cs, es;
    cs = LAP_W'(w[0]) + LAP_W'(w[2]) + LAP_W'(w[6]) + LAP_W'(w[8]);
    es = LAP_W'(w[1]) + LAP_W'(w[3]) + LAP_W'(w[5]) + LAP_W'(w[7]);
    return signed'(cs + (es << 2) - (LAP_W'(w[4]) << 4) - (LAP_W'(w[4]) << 2));
  endfunction

  // configuration
  logic [DIM_W-1:0] width_q, height_q;
  logic [PAR_W-1:0] da_q, db_q, feed_q, kill_q, dt_q;
  logic [DIM_W-1:0] w_eff, h_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(1024);
      height_q <= DIM_W'(1024);
      da_q     <= PAR_W'(16384);
      db_q     <= PAR_W'(8192);
      feed_q   <= PAR_W'(3604);
      kill_q   <= PAR_W'(4063);
      dt_q     <= PAR_W'(18022);
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_GRID_WIDTH:  width_q  <= cfg_wdata_i[DIM_W-1:0];
        REG_GRID_HEIGHT: height_q <= cfg_wdata_i[DIM_W-1:0];
        REG_DIFF_A:      da_q     <= cfg_wdata_i;
        REG_DIFF_B:      db_q     <= cfg_wdata_i;
        REG_FEED:        feed_q   <= cfg_wdata_i;
        REG_KILL:        kill_q   <= cfg_wdata_i;
        REG_TIME_STEP:   dt_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign w_eff = (width_q < DIM_W'(3)) ? DIM_W'(3) :
                 (width_q > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_q;
  assign h_eff = (height_q < DIM_W'(3)) ? DIM_W'(3) :
                 (height_q > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_q;

  // counters and the accepted beat
  logic [POS_W-1:0]  col_q, row_q, cc_q, rr_q;
  logic [POS_W-1:0]  c_eff, r_eff;
  logic [DIM_W-1:0]  c_nx, r_nx;
  logic [CONC_W-1:0] ia_q, ib_q;
  logic [ADDR_W-1:0] cur_addr, prev_addr, wr_addr_q;

  assign c_eff     = first_of_frame_i ? '0 : col_q;
  assign r_eff     = first_of_frame_i ? '0 : row_q;
  assign c_nx      = DIM_W'(c_eff) + 1'b1;
  assign r_nx      = DIM_W'(r_eff) + 1'b1;
  assign cur_addr  = {r_eff[0], c_eff};
  assign prev_addr = {~r_eff[0], c_eff};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.accept) begin
      if (c_nx >= w_eff) begin
        col_q <= '0;
        row_q <= (r_nx >= h_eff) ? '0 : r_nx[POS_W-1:0];
      end else begin
        col_q <= c_nx[POS_W-1:0];
        row_q <= r_eff;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cc_q      <= c_eff;
      rr_q      <= r_eff;
      ia_q      <= conc_a_i;
      ib_q      <= conc_b_i;
      wr_addr_q <= cur_addr;
    end
  end

  // line stores, read at accept, written at shift
  logic [CONC_W-1:0] mem_a [2*MAX_WIDTH];
  logic [CONC_W-1:0] mem_b [2*MAX_WIDTH];
  logic [CONC_W-1:0] rd_a_cur_q, rd_a_prev_q, rd_b_cur_q, rd_b_prev_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rd_a_cur_q  <= mem_a[cur_addr];
      rd_a_prev_q <= mem_a[prev_addr];
      rd_b_cur_q  <= mem_b[cur_addr];
      rd_b_prev_q <= mem_b[prev_addr];
    end
    if (cmd_i.shift) begin
      mem_a[wr_addr_q] <= ia_q;
      mem_b[wr_addr_q] <= ib_q;
    end
  end

  // windows
  logic [8:0][CONC_W-1:0] win_a_q, win_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_a_q <= '0;
      win_b_q <= '0;
    end else if (cmd_i.shift) begin
      win_a_q <= {ia_q, win_a_q[8], win_a_q[7], rd_a_prev_q, win_a_q[5], win_a_q[4],
                  rd_a_cur_q, win_a_q[2], win_a_q[1]};
      win_b_q <= {ib_q, win_b_q[8], win_b_q[7], rd_b_prev_q, win_b_q[5], win_b_q[4],
                  rd_b_cur_q, win_b_q[2], win_b_q[1]};
    end
  end

  // emitted position
  logic             emit, interior, interior_q;
  logic [POS_W-1:0] orow, ocol, orow_q, ocol_q;

  assign emit     = (rr_q >= POS_W'(2)) || (rr_q == POS_W'(1) && cc_q != '0);
  assign orow     = (cc_q != '0) ? rr_q - 1'b1 : rr_q - POS_W'(2);
  assign ocol     = (cc_q != '0) ? cc_q - 1'b1 : POS_W'(w_eff - 1'b1);
  assign interior = (orow != '0) && (DIM_W'(orow) + DIM_W'(2) <= h_eff) &&
                    (ocol != '0) && (DIM_W'(ocol) + DIM_W'(2) <= w_eff);

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) begin
      orow_q     <= orow;
      ocol_q     <= ocol;
      interior_q <= interior;
    end
  end

  // operand selection for the serial unit
  logic [CONC_W-1:0]       ca, cb;
  logic signed [VAL_W-1:0] t_ab, t_abb, t_da, t_fa, t_db, t_kb, t_rate, t_pa, t_pb;
  logic signed [VAL_W-1:0] mcand, num_a, num_b, num, res;
  logic [MPL_W-1:0]        mplier;
  logic                    is_div, unit_done;

  assign ca = win_a_q[4];
  assign cb = win_b_q[4];

  assign num_a = (t_da <<< 17) - (t_abb <<< 5) - (t_abb <<< 3) +
                 (t_fa <<< 19) + (t_fa <<< 17);
  assign num_b = (t_db <<< 17) + (t_abb <<< 5) + (t_abb <<< 3) -
                 (t_kb <<< 19) - (t_kb <<< 17);

  always_comb begin
    mcand  = '0;
    mplier = '0;
    num    = num_a;
    is_div = 1'b0;
    case (cmd_i.op)
      OP_AB:  begin mcand = VAL_W'(ca);  mplier = MPL_W'(cb);   end
      OP_ABB: begin mcand = t_ab;        mplier = MPL_W'(cb);   end
      OP_DA:  begin mcand = VAL_W'(lap20(win_a_q)); mplier = MPL_W'(da_q); end
      OP_FA:  begin
        mcand  = VAL_W'(ONE_Q15) - VAL_W'(ca);
        mplier = MPL_W'(feed_q);
      end
      OP_DB:  begin mcand = VAL_W'(lap20(win_b_q)); mplier = MPL_W'(db_q); end
      OP_KB:  begin
        mcand  = VAL_W'(cb);
        mplier = MPL_W'(kill_q) + MPL_W'(feed_q);
      end
      OP_DVA: begin is_div = 1'b1; num = num_a; end
      OP_DTA: begin mcand = t_rate; mplier = MPL_W'(dt_q); end
      OP_DVB: begin is_div = 1'b1; num = num_b; end
      OP_DTB: begin mcand = t_rate; mplier = MPL_W'(dt_q); end
      default: ;
    endcase
  end

  gsrd_unit u_unit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.start),
    .is_div_i (is_div),
    .mcand_i  (mcand),
    .mplier_i (mplier),
    .num_i    (num),
    .done_o   (unit_done),
    .result_o (res)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture && unit_done) begin
      case (cmd_i.op)
        OP_AB:  t_ab   <= res;
        OP_ABB: t_abb  <= res;
        OP_DA:  t_da   <= res;
        OP_FA:  t_fa   <= res;
        OP_DB:  t_db   <= res;
        OP_KB:  t_kb   <= res;
        OP_DVA: t_rate <= res;
        OP_DTA: t_pa   <= res;
        OP_DVB: t_rate <= res;
        OP_DTB: t_pb   <= res;
        default: ;
      endcase
    end
  end

  // output beat
  logic [CONC_W-1:0] na, nb, diff;
  logic [23:0]       prod;
  logic [8:0]        lum9;
  logic [7:0]        lum;
  logic              out_valid_q;

  assign na   = interior_q ? settle(ca, t_pa) : ca;
  assign nb   = interior_q ? settle(cb, t_pb) : cb;
  assign diff = na - nb;
  assign prod = {diff, 8'd0} - 24'(diff);
  assign lum9 = prod[23:15];
  assign lum  = (na <= nb) ? 8'd0 : (lum9 > 9'd255) ? 8'd255 : lum9[7:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      new_a_o     <= na;
      new_b_o     <= nb;
      luminance_o <= lum;
      out_row_o   <= orow_q;
      out_col_o   <= ocol_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign stat_o.emit      = emit;
  assign stat_o.interior  = interior;
  assign stat_o.unit_done = unit_done;
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;

endmodule

>>> rtl/core/gsrd_ctrl.sv
// controller: sequences accept, window shift, arithmetic steps and the output load
// depends on gsrd_pkg
module gsrd_ctrl import gsrd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_START,
    ST_WAIT,
    ST_FIN
  } state_e;

  state_e state_q;
  op_e    op_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_AB;
    end else begin
      case (state_q)
        ST_IDLE:  if (in_valid_i) state_q <= ST_SHIFT;
        ST_SHIFT: begin
          op_q <= OP_AB;
          if (!stat_i.emit)         state_q <= ST_IDLE;
          else if (stat_i.interior) state_q <= ST_START;
          else                      state_q <= ST_FIN;
        end
        ST_START: state_q <= ST_WAIT;
        ST_WAIT: begin
          if (stat_i.unit_done) begin
            if (op_q == OP_DTB) begin
              state_q <= ST_FIN;
            end else begin
              op_q    <= op_e'(op_q + 1'b1);
              state_q <= ST_START;
            end
          end
        end
        ST_FIN:   if (stat_i.out_free) state_q <= ST_IDLE;
        default:  state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o       = (state_q != ST_IDLE);
  assign cmd_o.accept     = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.shift      = (state_q == ST_SHIFT);
  assign cmd_o.start      = (state_q == ST_START);
  assign cmd_o.capture    = (state_q == ST_WAIT);
  assign cmd_o.load_out   = (state_q == ST_FIN) && stat_i.out_free;
  assign cmd_o.op         = op_q;

endmodule
